### src/nested_region_time_profiler_unit_macros.svh
`ifndef NESTED_REGION_TIME_PROFILER_UNIT_MACROS_SVH
`define NESTED_REGION_TIME_PROFILER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NRTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define NRTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/nrtp_pkg.sv
`timescale 1ns / 1ps

package nrtp_pkg;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned ID_TABLE_N = 256;

  localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_ON  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_BITS = 1'd1;

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_STOP  = 2'd1,
    FN_READ  = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TIME_W-1:0] now;
  } stk_cmd_t;

  typedef struct packed {
    logic rd_en;
    logic tot_we;
    logic cnt_we;
  } tbl_ctl_t;

endpackage

### src/nrtp_stack.sv
`timescale 1ns / 1ps

module nrtp_stack #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned IDX_W       = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  nrtp_pkg::stk_cmd_t                     cmd_i,
  input  logic [IDX_W-1:0]                       id_i,
  output logic [IDX_W-1:0]                       top_id_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]       level_o,
  output logic                                   empty_o,
  output logic                                   full_o,
  output logic [nrtp_pkg::TIME_W-1:0]            start_time_o
);
  import nrtp_pkg::*;

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STK_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [IDX_W-1:0]  stack_q [STACK_DEPTH];
  logic [LVL_W-1:0]  level_q, level_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [STK_W-1:0]  top_idx;

  assign top_idx      = STK_W'(level_q - LVL_W'(1));
  assign top_id_o     = stack_q[top_idx];
  assign level_o      = level_q;
  assign empty_o      = (level_q == '0);
  assign full_o       = (level_q == LVL_W'(STACK_DEPTH));
  assign start_time_o = start_q;

  always_comb begin
    level_d = level_q;
    start_d = start_q;
    if (cmd_i.push) begin
      level_d = level_q + LVL_W'(1);
      start_d = cmd_i.now;
    end else if (cmd_i.pop) begin
      level_d = level_q - LVL_W'(1);
      start_d = cmd_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      start_q <= '0;
    end else begin
      level_q <= level_d;
      start_q <= start_d;
    end
  end

  // entries above the level are never read, so no reset here
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[level_q[STK_W-1:0]] <= id_i;
    end
  end

endmodule

### src/nrtp_tables.sv
`timescale 1ns / 1ps

module nrtp_tables #(
  parameter int unsigned REGION_COUNT = 256,
  parameter int unsigned IDX_W        = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nrtp_pkg::tbl_ctl_t           ctl_i,
  input  logic [IDX_W-1:0]             tot_raddr_i,
  input  logic [IDX_W-1:0]             cnt_raddr_i,
  input  logic [IDX_W-1:0]             tot_waddr_i,
  input  logic [IDX_W-1:0]             cnt_waddr_i,
  input  logic [nrtp_pkg::TIME_W-1:0]  tot_wdata_i,
  input  logic [nrtp_pkg::CNT_W-1:0]   cnt_wdata_i,
  output logic [nrtp_pkg::TIME_W-1:0]  tot_rdata_o,
  output logic [nrtp_pkg::CNT_W-1:0]   cnt_rdata_o,
  output logic                         busy_o
);
  import nrtp_pkg::*;

  logic [TIME_W-1:0] tot_mem [REGION_COUNT];
  logic [CNT_W-1:0]  cnt_mem [REGION_COUNT];
  logic [TIME_W-1:0] tot_rdata_q;
  logic [CNT_W-1:0]  cnt_rdata_q;

  logic             clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  // zeroing sweep after reset, one entry of each table per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_W'(REGION_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      tot_mem[clr_idx_q] <= '0;
    end else if (ctl_i.tot_we) begin
      tot_mem[tot_waddr_i] <= tot_wdata_i;
    end
    if (ctl_i.rd_en) begin
      tot_rdata_q <= tot_mem[tot_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      cnt_mem[clr_idx_q] <= '0;
    end else if (ctl_i.cnt_we) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    if (ctl_i.rd_en) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr_i];
    end
  end

  assign tot_rdata_o = tot_rdata_q;
  assign cnt_rdata_o = cnt_rdata_q;
  assign busy_o      = clr_busy_q;

endmodule

### src/nested_region_time_profiler_unit.sv
`timescale 1ns / 1ps
// Exclusive-time profiler for nested regions.
// Input stream: one transaction per event. tuser carries the event kind
// (start, stop, read), tdata the region id, the count flag and the cycle
// counter value. Output stream: one transaction per event with a status,
// and for a read the region total (shifted right by skip_bits) and count.
// Configuration: cfg_we_i/cfg_addr_i/cfg_data_i write timer_on (index 0)
// and skip_bits (index 1); the user must write them only while no event
// is in flight, which the block does not enforce. Timing: each event is
// a read-modify-write of the totals and counts memories (read at accept,
// write back in the EXEC state once the output is free); the next event
// is accepted only after that write back, which also loads the result.
// Reset: stack empty, start time zero, registers zero; then a zeroing pass
// over every entry of both memories, during which no event is accepted
// (configuration writes are still taken).
// Stall: the result register holds a waiting result; one more event may be
// accepted and is held in the EXEC state until the output frees up.
module nested_region_time_profiler_unit #(
  parameter int unsigned STACK_DEPTH  = 16,
  parameter int unsigned REGION_COUNT = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nrtp_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [nrtp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // op_id[7:0], count_it[8], time_now[72:9], zero fill
  input  logic [nrtp_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // func[1:0]
  input  logic [nrtp_pkg::FUNC_W-1:0]       s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status[1:0], total_time[65:2], call_count[97:66], zero fill
  output logic [nrtp_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import nrtp_pkg::*;

  `include "nested_region_time_profiler_unit_macros.svh"

  localparam int unsigned IDX_W = $clog2(REGION_COUNT);
  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  logic              timer_on_q;
  logic [SHIFT_W-1:0] skip_q;

  // input fields
  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0]   in_op_id;
  logic              in_count_it;
  logic [TIME_W-1:0] in_now;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  id_map [ID_TABLE_N];

  logic accept;

  // stack
  stk_cmd_t          stk_cmd;
  logic [IDX_W-1:0]  top_id;
  logic [LVL_W-1:0]  level;
  logic              stk_empty, stk_full;
  logic [TIME_W-1:0] start_time;

  // tables
  tbl_ctl_t          tbl_ctl;
  logic [IDX_W-1:0]  tot_raddr;
  logic [TIME_W-1:0] tot_rdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              tbl_busy;

  // event held from accept to write back
  logic              charge_q, charge_d;
  logic              count_q, count_d;
  logic              read_q, read_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TIME_W-1:0] elapsed_q;
  logic [IDX_W-1:0]  tot_addr_q, cnt_addr_q;

  logic              emit;
  logic              out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [TIME_W-1:0] total_out;
  logic [CNT_W-1:0]  count_out;

  assign in_func     = s_axis_tuser_i;
  assign in_op_id    = s_axis_tdata_i[7:0];
  assign in_count_it = s_axis_tdata_i[8];
  assign in_now      = s_axis_tdata_i[72:9];

  // region id folded onto the table size
  for (genvar g = 0; g < ID_TABLE_N; g++) begin : g_id_map
    assign id_map[g] = IDX_W'(g % REGION_COUNT);
  end
  assign in_idx = id_map[in_op_id];

  assign s_axis_tready_o = (state_q == ST_IDLE) && !tbl_busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_on_q <= 1'b0;
      skip_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TIMER_ON:  timer_on_q <= cfg_data_i[0];
        CFG_SKIP_BITS: skip_q     <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode on accept: stack moves now, table update happens at write back in EXEC
  always_comb begin
    stk_cmd.push = 1'b0;
    stk_cmd.pop  = 1'b0;
    stk_cmd.now  = in_now;
    charge_d     = 1'b0;
    count_d      = 1'b0;
    read_d       = 1'b0;
    status_d     = STATUS_OK;
    tot_raddr    = top_id;
    if (accept) begin
      case (in_func)
        FN_START: begin
          if (timer_on_q) begin
            if (stk_full) begin
              status_d = STATUS_FULL;
            end else begin
              stk_cmd.push = 1'b1;
              charge_d     = !stk_empty;
              count_d      = in_count_it;
            end
          end
        end
        FN_STOP: begin
          if (timer_on_q) begin
            if (stk_empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              stk_cmd.pop = 1'b1;
              charge_d    = 1'b1;
            end
          end
        end
        FN_READ: begin
          read_d    = 1'b1;
          tot_raddr = in_idx;
        end
        default: ;
      endcase
    end
  end

  nrtp_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .IDX_W       (IDX_W)
  ) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (stk_cmd),
    .id_i         (in_idx),
    .top_id_o     (top_id),
    .level_o      (level),
    .empty_o      (stk_empty),
    .full_o       (stk_full),
    .start_time_o (start_time)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      charge_q   <= charge_d;
      count_q    <= count_d;
      read_q     <= read_d;
      status_q   <= status_d;
      elapsed_q  <= in_now - start_time;
      tot_addr_q <= tot_raddr;
      cnt_addr_q <= in_idx;
    end
  end

  // EXEC state: write back and load the result once the output is free
  assign emit = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);

  assign tbl_ctl.rd_en  = accept;
  assign tbl_ctl.tot_we = emit && charge_q;
  assign tbl_ctl.cnt_we = emit && count_q && (cnt_rdata != '1);

  nrtp_tables #(
    .REGION_COUNT (REGION_COUNT),
    .IDX_W        (IDX_W)
  ) u_tables (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (tbl_ctl),
    .tot_raddr_i (tot_raddr),
    .cnt_raddr_i (in_idx),
    .tot_waddr_i (tot_addr_q),
    .cnt_waddr_i (cnt_addr_q),
    .tot_wdata_i (tot_rdata + elapsed_q),
    .cnt_wdata_i (cnt_rdata + CNT_W'(1)),
    .tot_rdata_o (tot_rdata),
    .cnt_rdata_o (cnt_rdata),
    .busy_o      (tbl_busy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (emit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign total_out = read_q ? (tot_rdata >> skip_q) : '0;
  assign count_out = read_q ? cnt_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {6'b0, count_out, total_out, status_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `NRTP_ASSERT_IMP(a_no_accept_in_clear, accept, !tbl_busy, "event accepted during table clear")
  `NRTP_ASSERT_NEXT(a_rmw_interlock, accept, !s_axis_tready_o, "back-to-back accept over rmw")
  `NRTP_ASSERT_IMP(a_level_bound, 1'b1, level <= LVL_W'(STACK_DEPTH), "stack level past depth")
  `NRTP_ASSERT_NEXT(a_emit_loads_out, emit, m_axis_tvalid_o, "result lost after write back")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nrtp_pkg::*;

  localparam int unsigned STACK_N   = 16;
  localparam int unsigned REGIONS   = ID_TABLE_N;
  localparam int unsigned CYCLE_CAP = 1000000;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct {
    status_e         status;
    bit [TIME_W-1:0] total;
    bit [CNT_W-1:0]  count;
  } region_report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [FUNC_W-1:0]     s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  nested_region_time_profiler_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // profiler image kept by the testbench
  bit                 timer_on_q;
  bit [SHIFT_W-1:0]   skip_q;
  bit [ID_W-1:0]      region_stack_q [STACK_N];
  int unsigned        depth_q;
  bit [TIME_W-1:0]    top_start_q;
  bit [TIME_W-1:0]    totals_q [REGIONS];
  bit [CNT_W-1:0]     counts_q [REGIONS];

  region_report_t     report_queue [$];
  region_report_t     due_report;
  int unsigned        mismatches;
  int unsigned        cycle_cnt;
  int unsigned        hold_left;
  bit                 burst_mode;
  bit [TIME_W-1:0]    stamp;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // charges, pushes, pops and reads exactly as the block should
  function automatic region_report_t account_event(input logic [FUNC_W-1:0] fn,
                                                   input logic [ID_W-1:0] id,
                                                   input logic cnt,
                                                   input logic [TIME_W-1:0] now);
    region_report_t rep;
    rep.status = STATUS_OK;
    rep.total  = '0;
    rep.count  = '0;
    if (fn == FN_START && timer_on_q) begin
      if (depth_q >= STACK_N) begin
        rep.status = STATUS_FULL;
      end else begin
        if (depth_q != 0) totals_q[region_stack_q[depth_q-1]] += now - top_start_q;
        region_stack_q[depth_q] = id;
        depth_q++;
        top_start_q = now;
        if (cnt && counts_q[id] != '1) counts_q[id]++;
      end
    end else if (fn == FN_STOP && timer_on_q) begin
      if (depth_q == 0) begin
        rep.status = STATUS_EMPTY;
      end else begin
        totals_q[region_stack_q[depth_q-1]] += now - top_start_q;
        depth_q--;
        top_start_q = now;
      end
    end else if (fn == FN_READ) begin
      rep.total = totals_q[id] >> skip_q;
      rep.count = counts_q[id];
    end
    return rep;
  endfunction

  task automatic note_mismatch(input string what, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
    if (mismatches < 100)
      $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                            input logic cnt, input logic [TIME_W-1:0] now);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fn;
    s_axis_tdata_i  <= {{(IN_DATA_W-73){1'b0}}, now, cnt, id};
    do @(posedge clk_i); while (!s_axis_tready_o);
    report_queue.push_back(account_event(fn, id, cnt, now));
    gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_profiler(input bit run_en, input bit [SHIFT_W-1:0] shift);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_TIMER_ON;
    cfg_data_i <= {{(CFG_DATA_W-1){1'b0}}, run_en};
    @(posedge clk_i);
    cfg_addr_i <= CFG_SKIP_BITS;
    cfg_data_i <= shift;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    timer_on_q = run_en;
    skip_q     = shift;
  endtask

  // n counts events the block acts on; ignored starts and stops and unused codes come on top
  task automatic run_random(input int unsigned n);
    int unsigned       done;
    int unsigned       r;
    logic [FUNC_W-1:0] fn;
    logic [ID_W-1:0]   id;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 18) fn = FN_READ;
      else if (r < 20) fn = FN_UNUSED;
      else if (depth_q == 0) fn = (r < 26) ? FN_STOP : FN_START;
      else if (depth_q >= STACK_N) fn = (r < 26) ? FN_START : FN_STOP;
      else fn = (r < 61) ? FN_START : FN_STOP;
      // a few hot regions so reads see real totals
      r = $urandom_range(0, 99);
      if (r < 70) id = ID_W'($urandom_range(0, 7));
      else if (r < 80) id = (r < 75) ? '0 : '1;
      else id = ID_W'($urandom_range(0, REGIONS-1));
      r = $urandom_range(0, 99);
      if (r < 85) stamp += TIME_W'($urandom_range(0, 500));
      else if (r < 93) stamp += {$urandom(), $urandom()} >> $urandom_range(0, 63);
      else if (r < 97) stamp = {$urandom(), $urandom()};
      else stamp = '1 - TIME_W'($urandom_range(0, 200));
      if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
      if (fn == FN_READ || (timer_on_q && fn != FN_UNUSED)) done++;
      send_event(fn, id, 1'($urandom_range(0, 1)), stamp);
    end
  endtask

  task automatic test_reset_state();
    send_event(FN_READ, '0, 1'b0, '0);
    send_event(FN_READ, '1, 1'b1, '1);
    send_event(FN_UNUSED, 8'd9, 1'b1, 64'd77);
    // timer is off after reset, so these leave no trace
    send_event(FN_START, 8'd5, 1'b1, 64'd100);
    send_event(FN_STOP, 8'd5, 1'b0, 64'd900);
    wait_idle();
  endtask

  task automatic test_stack_limits();
    logic [TIME_W-1:0] t;
    program_profiler(1'b1, '0);
    send_event(FN_STOP, 8'd1, 1'b0, 64'd50);
    for (int i = 0; i < STACK_N; i++) begin
      t = (i == STACK_N-1) ? '1 : TIME_W'(i) * 64'h1111_1111_1111_1111;
      send_event(FN_START, ID_W'((i == STACK_N-1) ? 255 : i * 17), i[0], t);
    end
    send_event(FN_START, 8'd3, 1'b1, '0);
    // elapsed wraps through zero
    send_event(FN_STOP, 8'd0, 1'b0, '0);
    send_event(FN_READ, '0, 1'b0, '0);
    send_event(FN_READ, '1, 1'b0, '0);
    wait_idle();
  endtask

  task automatic test_nesting_plain();
    run_random(300);
    wait_idle();
  endtask

  task automatic test_shift_extremes();
    program_profiler(1'b1, '1);
    run_random(150);
    wait_idle();
    program_profiler(1'b1, 6'd1);
    run_random(150);
    wait_idle();
  endtask

  task automatic test_timer_off();
    program_profiler(1'b0, SHIFT_W'($urandom_range(0, 63)));
    run_random(40);
    wait_idle();
  endtask

  task automatic test_shift_random();
    for (int k = 0; k < 6; k++) begin
      program_profiler(1'b1, SHIFT_W'($urandom_range(0, 63)));
      run_random(150);
      wait_idle();
    end
  endtask

  // result side: check each transaction, then decide ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (report_queue.size() == 0) begin
        note_mismatch("result with nothing pending", m_axis_tdata_o[65:2], '0);
      end else begin
        due_report = report_queue.pop_front();
        if (m_axis_tdata_o[1:0] !== due_report.status)
          note_mismatch("status", TIME_W'(m_axis_tdata_o[1:0]),
                        TIME_W'(due_report.status));
        if (m_axis_tdata_o[65:2] !== due_report.total)
          note_mismatch("total_time", m_axis_tdata_o[65:2], due_report.total);
        if (m_axis_tdata_o[97:66] !== due_report.count)
          note_mismatch("call_count", TIME_W'(m_axis_tdata_o[97:66]),
                        TIME_W'(due_report.count));
      end
    end
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!burst_mode && $urandom_range(0, 3) == 0) hold_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("nested_region_time_profiler_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_stack_limits();
    test_nesting_plain();
    test_shift_extremes();
    test_timer_off();
    test_shift_random();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("nested_region_time_profiler_unit verification clean");
    end else begin
      $display("nested_region_time_profiler_unit verification failed");
    end
    $finish;
  end

endmodule
